// File: rtl/assert_macros.svh
// Assertion macros for the selector RTL (used by lgss_engine).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

// File: rtl/lgss_pkg.sv
// -----------------------------------------------------------------------------
// lgss_pkg
// Shared types and constants for the lazy greedy seed selector.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
package lgss_pkg;
   localparam int MaxNodesDef = 1024;
   localparam int MaxSeedsDef = 64;
   localparam int FracBitsDef = 8;
   localparam int GainW       = 33;
   localparam int TotalW      = 40;
   localparam int NodeW       = 10;
   localparam int RoundW      = 7;
   localparam int NodeCountW  = 11;
   localparam int SeedCountW  = 7;
   localparam int CfgAddrW    = 1;
   localparam int CfgDataW    = 11;
   localparam int ReqDataW    = 40;
   localparam int RspDataW    = 56;

   localparam logic [CfgAddrW-1:0] CFG_NODE_COUNT = 1'b0;
   localparam logic [CfgAddrW-1:0] CFG_SEED_COUNT = 1'b1;

   typedef enum logic [1:0] {
      KIND_EVAL   = 2'd0,
      KIND_SELECT = 2'd1,
      KIND_DONE   = 2'd2
   } kind_type;

   typedef struct packed {
      logic                  start;
      logic [31:0]           spread;
   } cmd_type;

   typedef struct packed {
      kind_type              kind;
      logic [NodeW-1:0]      node;
      logic signed [GainW-1:0] gain;
      logic [RoundW-1:0]     rnd;
      logic                  last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT, ST_RD_TOP, ST_WR_TOP, ST_SIFT_RD, ST_SIFT_CMP,
      ST_SIFT_SWAP, ST_CHECK, ST_SELECT, ST_REMOVE, ST_EMIT2, ST_WAIT
   } state_type;
endpackage

// File: rtl/lgss_front.sv
// -----------------------------------------------------------------------------
// lgss_front
// Accepts request transactions and queues them as commands for the engine.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lgss_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  lgss_pkg::cmd_type     in_cmd,
   output logic                  out_valid,
   input  logic                  out_ready,
   output lgss_pkg::cmd_type     out_cmd
);
   // two-entry queue
   lgss_pkg::cmd_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rp_ff, rp_in, wp_ff, wp_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_cmd   = q_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rp_in  = rp_ff ^ pop;
      wp_in  = wp_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rp_ff  <= 1'b0;
         wp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rp_ff  <= rp_in;
         wp_ff  <= wp_in;
      end
      if (push) q_ff[wp_ff] <= in_cmd;
   end
endmodule

// File: rtl/lgss_engine.sv
// -----------------------------------------------------------------------------
// lgss_engine
// Heap engine: initializes the heap, evaluates estimates, sifts, selects and emits results.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lgss_engine #(
   parameter int MAX_NODES = lgss_pkg::MaxNodesDef,
   parameter int MAX_SEEDS = lgss_pkg::MaxSeedsDef,
   parameter int FRAC_BITS = lgss_pkg::FracBitsDef
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [lgss_pkg::NodeCountW-1:0] node_count,
   input  logic [lgss_pkg::SeedCountW-1:0] seed_count,
   input  logic                            cmd_valid,
   output logic                            cmd_ready,
   input  lgss_pkg::cmd_type               cmd,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output lgss_pkg::rsp_type               rsp
);
   localparam int AW = $clog2(MAX_NODES);
   localparam int SW = $clog2(MAX_NODES + 1);
   localparam int GW = lgss_pkg::GainW;
   localparam int TW = lgss_pkg::TotalW;
   localparam int RW = lgss_pkg::RoundW;
   localparam logic signed [GW-1:0] GMAX = {1'b0, {(GW-1){1'b1}}};
   localparam logic [RW:0] STAMP_NONE = {1'b1, {RW{1'b0}}};
   localparam logic [AW:0] PH0 = '0;
   localparam logic [AW:0] PH1 = (AW+1)'(1);
   localparam logic [AW:0] PH2 = (AW+1)'(2);
   localparam logic [AW:0] PH3 = (AW+1)'(3);

   // heap order and per-node gain/stamp; a start refills the active entries
   logic [AW-1:0]         ord_mem  [MAX_NODES];
   logic signed [GW-1:0]  gain_mem [MAX_NODES];
   logic [RW:0]           stmp_mem [MAX_NODES];

   lgss_pkg::state_type st_ff, st_in;
   logic [SW-1:0]         size_ff, size_in;
   logic [RW-1:0]         round_ff, round_in, target_ff, target_in;
   logic [TW-1:0]         total_ff, total_in;
   logic                  active_ff, active_in;
   logic signed [GW-1:0]  init_gain_ff, init_gain_in;
   logic [AW-1:0]         x_ff, x_in;            // sift position
   logic [AW-1:0]         xn_ff, xn_in;          // node at x
   logic signed [GW-1:0]  xg_ff, xg_in;
   logic [AW:0]           sub_ff, sub_in;        // phase of child fetch, clear count
   logic [AW-1:0]         c_ff, c_in, cn_ff, cn_in;
   logic signed [GW-1:0]  cg_ff, cg_in;
   logic                  post_ff, post_in;      // sift after removal
   logic                  rv_ff, rv_in;
   lgss_pkg::rsp_type     r_ff, r_in;
   logic [AW-1:0]         rn_ff, rn_in;          // right child node
   logic signed [GW-1:0]  sg_ff, sg_in;
   logic [31:0]           spread_ff, spread_in;

   // memory ports
   logic [AW-1:0] oa;  logic [AW-1:0] ord_q;
   logic [AW-1:0] na;  logic signed [GW-1:0] gain_q; logic [RW:0] stmp_q;
   logic          ow, nw;
   logic [AW-1:0] owa, owd, nwa;
   logic signed [GW-1:0] nwg; logic [RW:0] nws;
   logic [AW-1:0] ord_v;  logic signed [GW-1:0] gain_v; logic [RW:0] stmp_v;

   always_ff @(posedge clock) begin
      if (ow) ord_mem[owa] <= owd;
      if (nw) begin
         gain_mem[nwa] <= nwg;
         stmp_mem[nwa] <= nws;
      end
      ord_q  <= ord_mem[oa];
      gain_q <= gain_mem[na];
      stmp_q <= stmp_mem[na];
   end

   assign ord_v  = ord_q;
   assign gain_v = gain_q;
   assign stmp_v = stmp_q;

   logic [AW:0] cl, cr;
   logic signed [GW+1:0] diff;
   logic signed [TW+1:0] tsum;
   logic [SW-1:0] nsz;
   logic [SW:0]   nsat;
   logic [RW-1:0] ssat;
   logic [63:0]   init_wide;

   assign cl = {x_ff, 1'b1};
   assign cr = cl + 1'b1;
   assign diff = $signed({2'b00, spread_ff}) - $signed({1'b0, total_ff[GW:0]});
   assign tsum = $signed({2'b00, total_ff}) + (TW+2)'(xg_ff);

   always_comb begin
      nsat = (node_count == '0) ? (SW+1)'(1) :
             ((SW+1)'(node_count) > (SW+1)'(MAX_NODES) ? (SW+1)'(MAX_NODES)
                                                        : (SW+1)'(node_count));
      nsz  = SW'(nsat);
      ssat = (seed_count == '0) ? RW'(1) : seed_count;
      if (32'(ssat) > 32'(MAX_SEEDS)) ssat = RW'(MAX_SEEDS);
      if (32'(ssat) > 32'(nsz)) ssat = RW'(nsz);
      init_wide = (64'(nsat) + 64'd1) << FRAC_BITS;
   end

   assign cmd_ready = (st_ff == lgss_pkg::ST_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp       = r_ff;

   always_comb begin
      st_in = st_ff; size_in = size_ff; round_in = round_ff; target_in = target_ff;
      total_in = total_ff; active_in = active_ff; init_gain_in = init_gain_ff;
      x_in = x_ff; xn_in = xn_ff; xg_in = xg_ff; sub_in = sub_ff; c_in = c_ff;
      cn_in = cn_ff; cg_in = cg_ff; post_in = post_ff; rv_in = rv_ff; r_in = r_ff;
      rn_in = rn_ff; sg_in = sg_ff; spread_in = spread_ff;
      oa = '0; na = '0; ow = 1'b0; owa = '0; owd = '0; nw = 1'b0; nwa = '0;
      nwg = '0; nws = '0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (st_ff)
         lgss_pkg::ST_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               spread_in = cmd.spread;
               if (cmd.start) begin
                  size_in = nsz; round_in = '0; total_in = '0; target_in = ssat;
                  active_in = 1'b1;
                  init_gain_in = (init_wide > 64'(GMAX)) ? GMAX : GW'(init_wide);
                  st_in = lgss_pkg::ST_INIT; sub_in = PH0;
               end else if (active_ff && size_ff != '0) begin
                  st_in = lgss_pkg::ST_RD_TOP;
               end
            end
         end
         lgss_pkg::ST_INIT: begin
            // identity order, initial gain, no stamp: one entry a cycle
            ow = 1'b1; owa = sub_ff[AW-1:0]; owd = sub_ff[AW-1:0];
            nw = 1'b1; nwa = sub_ff[AW-1:0]; nwg = init_gain_ff; nws = STAMP_NONE;
            sub_in = sub_ff + 1'b1;
            if (32'(sub_ff) + 1 >= 32'(size_ff)) begin
               rv_in = 1'b1;
               r_in = '{lgss_pkg::KIND_EVAL, '0, '0, '0, 1'b1};
               st_in = lgss_pkg::ST_IDLE; sub_in = PH0;
            end
         end
         lgss_pkg::ST_RD_TOP: begin
            oa = '0; st_in = lgss_pkg::ST_WR_TOP; sub_in = PH0;
         end
         lgss_pkg::ST_WR_TOP: begin
            if (sub_ff == PH0) begin
               xn_in = ord_v; sub_in = PH1;
            end else begin
               sg_in = (diff > $signed({2'b00, GMAX})) ? GMAX :
                       (diff < -$signed({2'b00, GMAX}) - 1 ? ~GMAX : GW'(diff));
               nw = 1'b1; nwa = xn_ff; nwg = sg_in;
               nws = {1'b0, round_ff};
               xg_in = sg_in; x_in = '0; post_in = 1'b0;
               st_in = lgss_pkg::ST_SIFT_RD; sub_in = PH0;
            end
         end
         lgss_pkg::ST_SIFT_RD: begin
            // fetch left, then right child order and gains over cycles
            if ({1'b0, cl} >= {1'b0, size_ff} || cl[AW]) begin
               st_in = lgss_pkg::ST_CHECK; sub_in = PH0;
            end else begin
               oa = cl[AW-1:0]; st_in = lgss_pkg::ST_SIFT_CMP; sub_in = PH0;
            end
         end
         lgss_pkg::ST_SIFT_CMP: begin
            unique case (sub_ff[1:0])
               2'd0: begin na = ord_v; cn_in = ord_v; c_in = cl[AW-1:0];
                  oa = cr[AW-1:0]; sub_in = PH1; end
               2'd1: begin cg_in = gain_v;
                  if ({1'b0, cr} < {1'b0, size_ff} && !cr[AW]) begin
                     na = ord_v; sub_in = PH2;
                     rn_in = ord_v;
                  end else sub_in = PH3;
               end
               2'd2: begin
                  if (cg_ff < gain_v) begin
                     cg_in = gain_v; cn_in = rn_ff; c_in = cr[AW-1:0];
                  end
                  sub_in = PH3;
               end
               default: begin
                  if (xg_ff < cg_ff) st_in = lgss_pkg::ST_SIFT_SWAP;
                  else begin st_in = lgss_pkg::ST_CHECK; sub_in = PH0; end
               end
            endcase
         end
         lgss_pkg::ST_SIFT_SWAP: begin
            ow = 1'b1; owa = x_ff; owd = cn_ff;
            if (sub_ff[1:0] == 2'd3) sub_in = PH0;
            st_in = lgss_pkg::ST_WAIT;
         end
         lgss_pkg::ST_WAIT: begin
            ow = 1'b1; owa = c_ff; owd = xn_ff; x_in = c_ff;
            st_in = lgss_pkg::ST_SIFT_RD;
         end
         lgss_pkg::ST_CHECK: begin
            if (post_ff) begin
               st_in = lgss_pkg::ST_EMIT2; sub_in = PH0;
            end else if (sub_ff == PH0) begin
               oa = '0; sub_in = PH1;
            end else if (sub_ff == PH1) begin
               na = ord_v; xn_in = ord_v; sub_in = PH2;
            end else begin
               xg_in = gain_v;
               if (stmp_v != {1'b0, round_ff}) begin
                  if (!rv_ff || rsp_ready) begin
                     rv_in = 1'b1;
                     r_in = '{lgss_pkg::KIND_EVAL, 10'(xn_ff), '0, round_ff, 1'b1};
                     st_in = lgss_pkg::ST_IDLE;
                  end
               end else st_in = lgss_pkg::ST_SELECT;
            end
         end
         lgss_pkg::ST_SELECT: begin
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1;
               r_in = '{lgss_pkg::KIND_SELECT, 10'(xn_ff), xg_ff, round_ff, 1'b0};
               total_in = tsum < 0 ? '0 : (tsum[TW] ? {TW{1'b1}} : tsum[TW-1:0]);
               oa = AW'(size_ff - 1'b1);
               size_in = size_ff - 1'b1;
               round_in = round_ff + 1'b1;
               st_in = lgss_pkg::ST_REMOVE; sub_in = PH0;
            end
         end
         lgss_pkg::ST_REMOVE: begin
            if (sub_ff == PH0) begin
               ow = 1'b1; owa = '0; owd = ord_v; xn_in = ord_v; na = ord_v; sub_in = PH1;
            end else begin
               xg_in = gain_v; x_in = '0; post_in = 1'b1;
               st_in = lgss_pkg::ST_SIFT_RD; sub_in = PH0;
            end
         end
         lgss_pkg::ST_EMIT2: begin
            if (sub_ff == PH0) begin oa = '0; sub_in = PH1; end
            else if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1;
               if (round_ff >= target_ff || size_ff == '0) begin
                  active_in = 1'b0;
                  r_in = '{lgss_pkg::KIND_DONE, '0, '0, round_ff, 1'b1};
               end else
                  r_in = '{lgss_pkg::KIND_EVAL, 10'(ord_v), '0, round_ff, 1'b1};
               st_in = lgss_pkg::ST_IDLE;
            end
         end
         default: st_in = lgss_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= lgss_pkg::ST_IDLE; size_ff <= '0; round_ff <= '0; target_ff <= '0;
         total_ff <= '0; active_ff <= 1'b0; rv_ff <= 1'b0; sub_ff <= '0;
         post_ff <= 1'b0; init_gain_ff <= '0;
      end else begin
         st_ff <= st_in; size_ff <= size_in; round_ff <= round_in;
         target_ff <= target_in; total_ff <= total_in; active_ff <= active_in;
         rv_ff <= rv_in; sub_ff <= sub_in; post_ff <= post_in;
         init_gain_ff <= init_gain_in;
      end
      x_ff <= x_in; xn_ff <= xn_in; xg_ff <= xg_in; c_ff <= c_in; cn_ff <= cn_in;
      cg_ff <= cg_in; r_ff <= r_in; rn_ff <= rn_in; sg_ff <= sg_in;
      spread_ff <= spread_in;
   end

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
   `ASSERT_IMPLIES(a_size, clock, reset, 1'b1, 32'(size_ff) <= 32'(MAX_NODES), "heap too big")
   `ASSERT_IMPLIES(a_round, clock, reset, active_ff, round_ff <= target_ff, "round past target")
endmodule

// File: rtl/lazy_greedy_seed_selector_top.sv
// -----------------------------------------------------------------------------
// lazy_greedy_seed_selector_top
// Lazy greedy (CELF) seed selector around a max-heap keyed by marginal gain.
// -----------------------------------------------------------------------------
// channel | dir | contents
// req_    | in  | tdata: spread_estimate[31:0]; tuser: action
// rsp_    | out | tdata: node_index, gain, round_index; tuser: kind; tlast
// csr_    | in  | wr_en, index (0 node_count, 1 seed_count), data
//
// A start transaction refills the heap stores for the active node count, one
// entry a cycle, and then answers with an EVAL result.
// An estimate's time grows with each level its sift-down moves; a selection
// adds a second sift-down, and the pace is set by the single read port of
// each store.
// Reset is synchronous. The front queue takes up to two transactions while
// the engine works; results wait in a register until rsp_tready.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lazy_greedy_seed_selector_top #(
   parameter int MAX_NODES = lgss_pkg::MaxNodesDef,
   parameter int MAX_SEEDS = lgss_pkg::MaxSeedsDef,
   parameter int FRAC_BITS = lgss_pkg::FracBitsDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // spread_estimate
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // node_index[9:0], gain[42:10], round_index[49:43]
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_wr_en,
   input  logic [lgss_pkg::CfgAddrW-1:0] csr_index,
   input  logic [lgss_pkg::CfgDataW-1:0] csr_data
);
   logic [lgss_pkg::NodeCountW-1:0] node_count_ff;
   logic [lgss_pkg::SeedCountW-1:0] seed_count_ff;
   lgss_pkg::cmd_type in_cmd, q_cmd;
   lgss_pkg::rsp_type rsp;
   logic q_valid, q_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= lgss_pkg::NodeCountW'(1024);
         seed_count_ff <= lgss_pkg::SeedCountW'(64);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            lgss_pkg::CFG_NODE_COUNT: node_count_ff <= csr_data;
            lgss_pkg::CFG_SEED_COUNT: seed_count_ff <= csr_data[lgss_pkg::SeedCountW-1:0];
            default: ;
         endcase
      end
   end

   assign in_cmd.start  = ~req_tuser;
   assign in_cmd.spread = req_tdata;

   lgss_front u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready), .in_cmd,
      .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd));

   lgss_engine #(.MAX_NODES(MAX_NODES), .MAX_SEEDS(MAX_SEEDS), .FRAC_BITS(FRAC_BITS))
   u_engine (
      .clock, .reset, .node_count(node_count_ff), .seed_count(seed_count_ff),
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp);

   assign rsp_tdata = {6'd0, rsp.rnd, rsp.gain, rsp.node};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;
endmodule
